FILE: hw/rtl/bfla_pkg.sv
// Shared types, codes and constants for the block free list allocator.
// Used by bfla_links, bfla_seq and block_free_list_allocator; depends on nothing.
package bfla_pkg;

   localparam int BLK_W   = 4;
   localparam int CNT_W   = 5;
   localparam int CMD_W   = 3;
   localparam int STAT_W  = 2;
   localparam int BYTES_W = 9;
   localparam int PROD_W  = 14;
   localparam int BYTES_MAX = 511;
   localparam int UPC_W   = 5;

   localparam logic [CMD_W-1:0] CMD_ALLOC       = 3'd0;
   localparam logic [CMD_W-1:0] CMD_FREE        = 3'd1;
   localparam logic [CMD_W-1:0] CMD_TOP_GROW    = 3'd2;
   localparam logic [CMD_W-1:0] CMD_TOP_SHRINK  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_BOT_GROW    = 3'd4;
   localparam logic [CMD_W-1:0] CMD_BOT_SHRINK  = 3'd5;

   localparam logic [STAT_W-1:0] STAT_OK           = 2'd0;
   localparam logic [STAT_W-1:0] STAT_LIST_EMPTY   = 2'd1;
   localparam logic [STAT_W-1:0] STAT_REGIONS_MEET = 2'd2;
   localparam logic [STAT_W-1:0] STAT_REGION_EMPTY = 2'd3;

   typedef enum logic [1:0] {RD_NONE, RD_E, RD_HEAD} rd_sel_type;
   typedef enum logic [2:0] {WR_NONE, WR_UNLINK, WR_LINK_B, WR_LINK_HT, WR_SOLO} wr_op_type;
   typedef enum logic [2:0] {
      LD_NONE, LD_HEAD, LD_BI, LD_TOP, LD_TOP_M1, LD_BOT, LD_BOT_P1
   } ld_op_type;
   typedef enum logic [2:0] {CNT_NONE, CNT_INC_TOP, CNT_DEC_TOP, CNT_INC_BOT, CNT_DEC_BOT}
      cnt_op_type;
   typedef enum logic [2:0] {C_NEVER, C_EMPTY, C_FULL, C_BI_OOR, C_TOP_ZERO, C_BOT_ZERO}
      cond_type;

   // One horizontal control word. When the condition holds the word only jumps.
   typedef struct packed {
      cond_type              cond;
      logic [UPC_W-1:0]      jmp;
      logic [UPC_W-1:0]      nxt;
      rd_sel_type            rd;
      wr_op_type             wr;
      ld_op_type             ld;
      cnt_op_type            cnt;
      logic                  st_en;
      logic [STAT_W-1:0]     st;
      logic                  last;
   } ucode_type;

   typedef struct packed {
      logic empty;
      logic full;
      logic bi_oor;
      logic top_zero;
      logic bot_zero;
   } cond_flags_type;

   typedef struct packed {
      logic             en;
      logic [BLK_W-1:0] addr;
   } link_rd_type;

   typedef struct packed {
      logic             we;
      logic [BLK_W-1:0] addr;
      logic [BLK_W-1:0] data;
   } link_wr_type;

   // Reset ring runs h, h+1, h-1, h+2, h-2, ... and ends at block 0, with h = n/2.
   function automatic logic [BLK_W-1:0] ring_next(input logic [CNT_W-1:0] x,
                                                  input logic [CNT_W-1:0] n);
      logic [CNT_W:0] h;
      logic [CNT_W:0] xx;
      logic [CNT_W:0] r;
      h  = {2'b00, n[CNT_W-1:1]};
      xx = {1'b0, x};
      if (xx == h) begin
         r = h + 1'b1;
      end else if (xx > h) begin
         r = (h << 1) - xx;
      end else if (xx == '0) begin
         r = h;
      end else if (((h << 1) + 1'b1 - xx) < {1'b0, n}) begin
         r = (h << 1) + 1'b1 - xx;
      end else begin
         r = xx - 1'b1;
      end
      return r[BLK_W-1:0];
   endfunction

   function automatic logic [BLK_W-1:0] ring_prev(input logic [CNT_W-1:0] y,
                                                  input logic [CNT_W-1:0] n);
      logic [CNT_W:0] h;
      logic [CNT_W:0] yy;
      logic [CNT_W:0] r;
      h  = {2'b00, n[CNT_W-1:1]};
      yy = {1'b0, y};
      if (yy == h) begin
         r = '0;
      end else if (yy > h) begin
         r = (h << 1) + 1'b1 - yy;
      end else if (yy == '0) begin
         r = ((h << 1) < {1'b0, n}) ? (h << 1) : (CNT_W+1)'(1);
      end else begin
         r = (h << 1) - yy;
      end
      return r[BLK_W-1:0];
   endfunction

endpackage

FILE: hw/rtl/bfla_links.sv
// Next and previous link stores of the free ring, one write and one read port each.
// Sweeps the reset ring into both stores after reset. Depends on bfla_pkg.
module bfla_links #(
   parameter int NUM_BLOCKS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  bfla_pkg::link_rd_type    rd,
   input  bfla_pkg::link_wr_type    wr_next,
   input  bfla_pkg::link_wr_type    wr_prev,
   output logic [bfla_pkg::BLK_W-1:0] next_rd,
   output logic [bfla_pkg::BLK_W-1:0] prev_rd,
   output logic                     init_done
);

   localparam int IDX_W  = $clog2(NUM_BLOCKS);
   localparam int INIT_W = $clog2(NUM_BLOCKS + 1);

   logic [bfla_pkg::BLK_W-1:0] next_mem [NUM_BLOCKS];
   logic [bfla_pkg::BLK_W-1:0] prev_mem [NUM_BLOCKS];
   logic [bfla_pkg::BLK_W-1:0] next_rd_ff;
   logic [bfla_pkg::BLK_W-1:0] prev_rd_ff;
   logic [INIT_W-1:0]          init_cnt_ff;
   logic [INIT_W-1:0]          init_cnt_in;
   logic                       n_we;
   logic [IDX_W-1:0]           n_addr;
   logic [bfla_pkg::BLK_W-1:0] n_data;
   logic                       p_we;
   logic [IDX_W-1:0]           p_addr;
   logic [bfla_pkg::BLK_W-1:0] p_data;
   logic [bfla_pkg::CNT_W-1:0] init_blk;

   assign init_done   = (init_cnt_ff == INIT_W'(NUM_BLOCKS));
   assign init_cnt_in = init_done ? init_cnt_ff : init_cnt_ff + 1'b1;
   assign init_blk    = bfla_pkg::CNT_W'(init_cnt_ff);

   always_comb begin
      if (!init_done) begin
         n_we   = 1'b1;
         n_addr = init_cnt_ff[IDX_W-1:0];
         n_data = bfla_pkg::ring_next(init_blk, bfla_pkg::CNT_W'(NUM_BLOCKS));
         p_we   = 1'b1;
         p_addr = init_cnt_ff[IDX_W-1:0];
         p_data = bfla_pkg::ring_prev(init_blk, bfla_pkg::CNT_W'(NUM_BLOCKS));
      end else begin
         n_we   = wr_next.we;
         n_addr = wr_next.addr[IDX_W-1:0];
         n_data = wr_next.data;
         p_we   = wr_prev.we;
         p_addr = wr_prev.addr[IDX_W-1:0];
         p_data = wr_prev.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         init_cnt_ff <= '0;
      end else begin
         init_cnt_ff <= init_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (n_we) begin
         next_mem[n_addr] <= n_data;
      end
      if (p_we) begin
         prev_mem[p_addr] <= p_data;
      end
      if (rd.en) begin
         next_rd_ff <= next_mem[rd.addr[IDX_W-1:0]];
         prev_rd_ff <= prev_mem[rd.addr[IDX_W-1:0]];
      end
   end

   assign next_rd = next_rd_ff;
   assign prev_rd = prev_rd_ff;

endmodule

FILE: hw/rtl/bfla_seq.sv
// Microcode sequencer of the allocator: step counter, control store and branching.
// Depends on bfla_pkg for the control word and condition flag types.
module bfla_seq (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [bfla_pkg::CMD_W-1:0]   cmd,
   input  bfla_pkg::cond_flags_type     flags,
   input  logic                         out_busy,
   output bfla_pkg::ucode_type          uword,
   output logic                         act,
   output logic                         busy
);

   localparam logic [bfla_pkg::UPC_W-1:0] UA_ALLOC0    = 5'd0;
   localparam logic [bfla_pkg::UPC_W-1:0] UA_ALLOC1    = 5'd1;
   localparam logic [bfla_pkg::UPC_W-1:0] UA_TG0       = 5'd2;
   localparam logic [bfla_pkg::UPC_W-1:0] UA_TG1       = 5'd3;
   localparam logic [bfla_pkg::UPC_W-1:0] UA_UNLINK    = 5'd4;
   localparam logic [bfla_pkg::UPC_W-1:0] UA_BG0       = 5'd5;
   localparam logic [bfla_pkg::UPC_W-1:0] UA_BG1       = 5'd6;
   localparam logic [bfla_pkg::UPC_W-1:0] UA_FREE0     = 5'd7;
   localparam logic [bfla_pkg::UPC_W-1:0] UA_APP0      = 5'd8;
   localparam logic [bfla_pkg::UPC_W-1:0] UA_APP1      = 5'd9;
   localparam logic [bfla_pkg::UPC_W-1:0] UA_APP2      = 5'd10;
   localparam logic [bfla_pkg::UPC_W-1:0] UA_SOLO      = 5'd11;
   localparam logic [bfla_pkg::UPC_W-1:0] UA_TS0       = 5'd12;
   localparam logic [bfla_pkg::UPC_W-1:0] UA_BS0       = 5'd13;
   localparam logic [bfla_pkg::UPC_W-1:0] UA_ST_EMPTY  = 5'd14;
   localparam logic [bfla_pkg::UPC_W-1:0] UA_ST_FULL   = 5'd15;
   localparam logic [bfla_pkg::UPC_W-1:0] UA_ST_REGION = 5'd16;
   localparam logic [bfla_pkg::UPC_W-1:0] UA_DONE      = 5'd17;

   logic                         busy_ff;
   logic                         busy_in;
   logic [bfla_pkg::UPC_W-1:0]   upc_ff;
   logic [bfla_pkg::UPC_W-1:0]   upc_in;
   logic                         taken;

   function automatic bfla_pkg::ucode_type ucode_rom(input logic [bfla_pkg::UPC_W-1:0] a);
      bfla_pkg::ucode_type w;
      w = '0;
      unique case (a)
         UA_ALLOC0: begin
            w.cond = bfla_pkg::C_EMPTY; w.jmp = UA_ST_EMPTY; w.nxt = UA_ALLOC1;
            w.ld = bfla_pkg::LD_HEAD; w.rd = bfla_pkg::RD_HEAD;
         end
         UA_ALLOC1: begin
            w.wr = bfla_pkg::WR_UNLINK; w.last = 1'b1;
         end
         UA_TG0: begin
            w.cond = bfla_pkg::C_FULL; w.jmp = UA_ST_FULL; w.nxt = UA_TG1;
            w.ld = bfla_pkg::LD_TOP;
         end
         UA_TG1: begin
            w.cond = bfla_pkg::C_EMPTY; w.jmp = UA_ST_EMPTY; w.nxt = UA_UNLINK;
            w.rd = bfla_pkg::RD_E; w.cnt = bfla_pkg::CNT_INC_TOP;
         end
         UA_UNLINK: begin
            w.wr = bfla_pkg::WR_UNLINK; w.last = 1'b1;
         end
         UA_BG0: begin
            w.cond = bfla_pkg::C_FULL; w.jmp = UA_ST_FULL; w.nxt = UA_BG1;
            w.ld = bfla_pkg::LD_BOT;
         end
         UA_BG1: begin
            w.cond = bfla_pkg::C_EMPTY; w.jmp = UA_ST_EMPTY; w.nxt = UA_UNLINK;
            w.rd = bfla_pkg::RD_E; w.cnt = bfla_pkg::CNT_INC_BOT;
         end
         UA_FREE0: begin
            w.cond = bfla_pkg::C_BI_OOR; w.jmp = UA_DONE; w.nxt = UA_APP0;
            w.ld = bfla_pkg::LD_BI;
         end
         UA_APP0: begin
            w.cond = bfla_pkg::C_EMPTY; w.jmp = UA_SOLO; w.nxt = UA_APP1;
            w.rd = bfla_pkg::RD_HEAD;
         end
         UA_APP1: begin
            w.wr = bfla_pkg::WR_LINK_B; w.nxt = UA_APP2;
         end
         UA_APP2: begin
            w.wr = bfla_pkg::WR_LINK_HT; w.last = 1'b1;
         end
         UA_SOLO: begin
            w.wr = bfla_pkg::WR_SOLO; w.last = 1'b1;
         end
         UA_TS0: begin
            w.cond = bfla_pkg::C_TOP_ZERO; w.jmp = UA_ST_REGION; w.nxt = UA_APP0;
            w.ld = bfla_pkg::LD_TOP_M1; w.cnt = bfla_pkg::CNT_DEC_TOP;
         end
         UA_BS0: begin
            w.cond = bfla_pkg::C_BOT_ZERO; w.jmp = UA_ST_REGION; w.nxt = UA_APP0;
            w.ld = bfla_pkg::LD_BOT_P1; w.cnt = bfla_pkg::CNT_DEC_BOT;
         end
         UA_ST_EMPTY: begin
            w.st_en = 1'b1; w.st = bfla_pkg::STAT_LIST_EMPTY; w.last = 1'b1;
         end
         UA_ST_FULL: begin
            w.st_en = 1'b1; w.st = bfla_pkg::STAT_REGIONS_MEET; w.last = 1'b1;
         end
         UA_ST_REGION: begin
            w.st_en = 1'b1; w.st = bfla_pkg::STAT_REGION_EMPTY; w.last = 1'b1;
         end
         default: begin
            w.last = 1'b1;
         end
      endcase
      return w;
   endfunction

   function automatic logic [bfla_pkg::UPC_W-1:0] entry(input logic [bfla_pkg::CMD_W-1:0] c);
      logic [bfla_pkg::UPC_W-1:0] a;
      unique case (c)
         bfla_pkg::CMD_ALLOC:      a = UA_ALLOC0;
         bfla_pkg::CMD_FREE:       a = UA_FREE0;
         bfla_pkg::CMD_TOP_GROW:   a = UA_TG0;
         bfla_pkg::CMD_TOP_SHRINK: a = UA_TS0;
         bfla_pkg::CMD_BOT_GROW:   a = UA_BG0;
         bfla_pkg::CMD_BOT_SHRINK: a = UA_BS0;
         default:                  a = UA_DONE;
      endcase
      return a;
   endfunction

   assign uword = ucode_rom(upc_ff);

   always_comb begin
      unique case (uword.cond)
         bfla_pkg::C_EMPTY:    taken = flags.empty;
         bfla_pkg::C_FULL:     taken = flags.full;
         bfla_pkg::C_BI_OOR:   taken = flags.bi_oor;
         bfla_pkg::C_TOP_ZERO: taken = flags.top_zero;
         bfla_pkg::C_BOT_ZERO: taken = flags.bot_zero;
         default:              taken = 1'b0;
      endcase
   end

   // A final step waits while the previous result is still held at the output.
   assign act = busy_ff && !taken && !(uword.last && out_busy);

   always_comb begin
      busy_in = busy_ff;
      upc_in  = upc_ff;
      if (start) begin
         busy_in = 1'b1;
         upc_in  = entry(cmd);
      end else if (busy_ff && taken) begin
         upc_in = uword.jmp;
      end else if (act) begin
         if (uword.last) begin
            busy_in = 1'b0;
         end else begin
            upc_in = uword.nxt;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         upc_ff  <= UA_DONE;
      end else begin
         busy_ff <= busy_in;
         upc_ff  <= upc_in;
      end
   end

   assign busy = busy_ff;

endmodule

FILE: hw/rtl/block_free_list_allocator.sv
// Block free list allocator: a microcoded sequencer drives the link stores and counters.
// Each request runs its own microcode sequence, and its final step loads the result.
// The next request is taken the cycle after the result is loaded, so no request is
// accepted while another runs. A final step waits while the output still holds a result.
// Reset is synchronous; afterwards a sweep loads the reset ring into the link stores and
// no request is accepted until it ends.
module block_free_list_allocator #(
   parameter int NUM_BLOCKS  = 16,
   parameter int BLOCK_BYTES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // command[2:0], block_index[6:3], zero[7]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // given_block[3:0], status[5:4],
                                    // top_bytes[14:6], bottom_bytes[23:15]
);

   localparam int BLK_W  = bfla_pkg::BLK_W;
   localparam int CNT_W  = bfla_pkg::CNT_W;
   localparam int PROD_W = bfla_pkg::PROD_W;
   localparam int BYTES_W = bfla_pkg::BYTES_W;

   logic                          accept;
   logic                          init_done;
   logic                          seq_busy;
   logic                          act;
   bfla_pkg::ucode_type           uword;
   bfla_pkg::cond_flags_type      flags;
   bfla_pkg::link_rd_type         link_rd;
   bfla_pkg::link_wr_type         wr_next;
   bfla_pkg::link_wr_type         wr_prev;
   logic [BLK_W-1:0]              next_rd;
   logic [BLK_W-1:0]              prev_rd;

   logic [bfla_pkg::CMD_W-1:0]    cmd;
   logic [BLK_W-1:0]              bi_ff;
   logic [BLK_W-1:0]              e_ff;
   logic [BLK_W-1:0]              e_in;
   logic [BLK_W-1:0]              given_ff;
   logic [BLK_W-1:0]              given_in;
   logic [BLK_W-1:0]              head_ff;
   logic [BLK_W-1:0]              head_in;
   logic                          empty_ff;
   logic                          empty_in;
   logic [CNT_W-1:0]              top_ff;
   logic [CNT_W-1:0]              top_in;
   logic [CNT_W-1:0]              bot_ff;
   logic [CNT_W-1:0]              bot_in;
   logic                          self_link;

   logic                          rsp_valid_ff;
   logic [23:0]                   rsp_data_ff;
   logic [PROD_W-1:0]             top_prod;
   logic [PROD_W-1:0]             bot_prod;
   logic [BYTES_W-1:0]            top_bytes;
   logic [BYTES_W-1:0]            bot_bytes;
   logic [bfla_pkg::STAT_W-1:0]   status;
   logic                          load_rsp;

   assign req_tready = init_done && !seq_busy;
   assign accept     = req_tvalid && req_tready;
   assign cmd        = req_tdata[2:0];

   assign flags.empty    = empty_ff;
   assign flags.full     = ({1'b0, top_ff} + {1'b0, bot_ff}) >= (CNT_W+1)'(NUM_BLOCKS);
   assign flags.bi_oor   = {1'b0, bi_ff} >= CNT_W'(NUM_BLOCKS);
   assign flags.top_zero = (top_ff == '0);
   assign flags.bot_zero = (bot_ff == '0);

   bfla_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (accept),
      .cmd      (cmd),
      .flags    (flags),
      .out_busy (rsp_valid_ff && !rsp_tready),
      .uword    (uword),
      .act      (act),
      .busy     (seq_busy)
   );

   bfla_links #(
      .NUM_BLOCKS (NUM_BLOCKS)
   ) u_links (
      .clock     (clock),
      .reset     (reset),
      .rd        (link_rd),
      .wr_next   (wr_next),
      .wr_prev   (wr_prev),
      .next_rd   (next_rd),
      .prev_rd   (prev_rd),
      .init_done (init_done)
   );

   // A block whose successor is itself is the last one on the ring.
   assign self_link = (next_rd == e_ff);

   always_comb begin
      link_rd.en   = 1'b0;
      link_rd.addr = e_ff;
      if (act) begin
         case (uword.rd)
            bfla_pkg::RD_E: begin
               link_rd.en = 1'b1;
            end
            bfla_pkg::RD_HEAD: begin
               link_rd.en   = 1'b1;
               link_rd.addr = head_ff;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      wr_next  = '0;
      wr_prev  = '0;
      head_in  = head_ff;
      empty_in = empty_ff;
      if (act) begin
         case (uword.wr)
            bfla_pkg::WR_UNLINK: begin
               if (self_link) begin
                  empty_in = 1'b1;
               end else begin
                  if (e_ff == head_ff) begin
                     head_in = next_rd;
                  end
                  wr_next = '{we: 1'b1, addr: prev_rd, data: next_rd};
                  wr_prev = '{we: 1'b1, addr: next_rd, data: prev_rd};
               end
            end
            bfla_pkg::WR_LINK_B: begin
               wr_next = '{we: 1'b1, addr: e_ff, data: head_ff};
               wr_prev = '{we: 1'b1, addr: e_ff, data: prev_rd};
            end
            bfla_pkg::WR_LINK_HT: begin
               wr_next = '{we: 1'b1, addr: prev_rd, data: e_ff};
               wr_prev = '{we: 1'b1, addr: head_ff, data: e_ff};
            end
            bfla_pkg::WR_SOLO: begin
               head_in  = e_ff;
               empty_in = 1'b0;
               wr_next  = '{we: 1'b1, addr: e_ff, data: e_ff};
               wr_prev  = '{we: 1'b1, addr: e_ff, data: e_ff};
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      e_in     = e_ff;
      given_in = accept ? '0 : given_ff;
      if (act) begin
         case (uword.ld)
            bfla_pkg::LD_HEAD: begin
               e_in     = head_ff;
               given_in = head_ff;
            end
            bfla_pkg::LD_BI:     e_in = bi_ff;
            bfla_pkg::LD_TOP:    e_in = top_ff[BLK_W-1:0];
            bfla_pkg::LD_TOP_M1: e_in = BLK_W'(top_ff - 1'b1);
            bfla_pkg::LD_BOT:    e_in = BLK_W'(CNT_W'(NUM_BLOCKS - 1) - bot_ff);
            bfla_pkg::LD_BOT_P1: e_in = BLK_W'(CNT_W'(NUM_BLOCKS) - bot_ff);
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      top_in = top_ff;
      bot_in = bot_ff;
      if (act) begin
         case (uword.cnt)
            bfla_pkg::CNT_INC_TOP: top_in = top_ff + 1'b1;
            bfla_pkg::CNT_DEC_TOP: top_in = top_ff - 1'b1;
            bfla_pkg::CNT_INC_BOT: bot_in = bot_ff + 1'b1;
            bfla_pkg::CNT_DEC_BOT: bot_in = bot_ff - 1'b1;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= BLK_W'(NUM_BLOCKS / 2);
         empty_ff <= 1'b0;
         top_ff   <= '0;
         bot_ff   <= '0;
      end else begin
         head_ff  <= head_in;
         empty_ff <= empty_in;
         top_ff   <= top_in;
         bot_ff   <= bot_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         bi_ff <= req_tdata[6:3];
      end
      e_ff     <= e_in;
      given_ff <= given_in;
   end

   // Counts do not change on a final step, so the sizes are taken from the registers.
   assign top_prod  = PROD_W'(top_ff) * PROD_W'(BLOCK_BYTES);
   assign bot_prod  = PROD_W'(bot_ff) * PROD_W'(BLOCK_BYTES);
   assign top_bytes = (top_prod > PROD_W'(bfla_pkg::BYTES_MAX)) ?
                      BYTES_W'(bfla_pkg::BYTES_MAX) : top_prod[BYTES_W-1:0];
   assign bot_bytes = (bot_prod > PROD_W'(bfla_pkg::BYTES_MAX)) ?
                      BYTES_W'(bfla_pkg::BYTES_MAX) : bot_prod[BYTES_W-1:0];
   assign status    = uword.st_en ? uword.st : bfla_pkg::STAT_OK;
   assign load_rsp  = act && uword.last;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_data_ff <= {bot_bytes, top_bytes, status, given_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

FILE: tb/tb_block_free_list_allocator.sv
`timescale 1ns / 1ps
// Self-checking testbench for block_free_list_allocator: a predictor of the free ring and
// both stack regions runs beside the block. Depends only on bfla_pkg and the allocator RTL.
module tb_block_free_list_allocator;

   localparam int NUM_BLOCKS   = 16;
   localparam int BLOCK_BYTES  = 16;
   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 8;

   localparam int BLK_W     = bfla_pkg::BLK_W;
   localparam int CMD_W     = bfla_pkg::CMD_W;
   localparam int STAT_W    = bfla_pkg::STAT_W;
   localparam int BYTES_W   = bfla_pkg::BYTES_W;
   localparam int BYTES_MAX = bfla_pkg::BYTES_MAX;

   localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
   localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

   // Same layout as rsp_tdata, lowest field last.
   typedef struct packed {
      logic [BYTES_W-1:0] bottom_bytes;
      logic [BYTES_W-1:0] top_bytes;
      logic [STAT_W-1:0]  status;
      logic [BLK_W-1:0]   given_block;
   } alloc_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;   // command[2:0], block_index[6:3], zero[7]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;        // given_block[3:0], status[5:4],
                                  // top_bytes[14:6], bottom_bytes[23:15]

   // Predicted allocator state.
   logic [BLK_W-1:0] succ_link [NUM_BLOCKS];
   logic [BLK_W-1:0] pred_link [NUM_BLOCKS];
   logic [BLK_W-1:0] free_head;
   bit               free_empty;
   int               top_blocks;
   int               bot_blocks;

   alloc_result_type pending_results [$];
   int               held_blocks [$];
   int               mismatch_count = 0;
   int               send_idle_pct = 0;
   int               recv_idle_pct = 0;
   int               hold_req = 0;
   int               quiet_cycles = 0;

   block_free_list_allocator #(
      .NUM_BLOCKS (NUM_BLOCKS),
      .BLOCK_BYTES(BLOCK_BYTES)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic int region_bytes(int count);
      int b;
      b = count * BLOCK_BYTES;
      return (b > BYTES_MAX) ? BYTES_MAX : b;
   endfunction

   // Removes a block from the ring; the link entries of a lone block are left alone.
   function automatic void take_block(logic [BLK_W-1:0] blk);
      logic [BLK_W-1:0] nb;
      logic [BLK_W-1:0] pb;
      nb = succ_link[blk];
      pb = pred_link[blk];
      if (nb == blk) begin
         free_empty = 1'b1;
         return;
      end
      if (blk == free_head) begin
         free_head = nb;
      end
      succ_link[pb] = nb;
      pred_link[nb] = pb;
   endfunction

   // Inserts a block before the head or alone into an empty list; no check it was in use.
   function automatic void put_block(logic [BLK_W-1:0] blk);
      logic [BLK_W-1:0] hb;
      logic [BLK_W-1:0] tb;
      if (free_empty) begin
         free_head = blk;
         succ_link[blk] = blk;
         pred_link[blk] = blk;
         free_empty = 1'b0;
         return;
      end
      hb = free_head;
      tb = pred_link[hb];
      pred_link[blk] = tb;
      succ_link[blk] = hb;
      pred_link[hb] = blk;
      succ_link[tb] = blk;
   endfunction

   function automatic alloc_result_type predict_allocator(logic [CMD_W-1:0] cmd,
                                                          logic [BLK_W-1:0] idx);
      alloc_result_type r;
      bit               full;
      r = '0;
      full = (top_blocks + bot_blocks) >= NUM_BLOCKS;
      case (cmd)
         bfla_pkg::CMD_ALLOC: begin
            if (free_empty) begin
               r.status = bfla_pkg::STAT_LIST_EMPTY;
            end else begin
               r.given_block = free_head;
               take_block(free_head);
            end
         end
         bfla_pkg::CMD_FREE: begin
            if (idx < NUM_BLOCKS) begin
               put_block(idx);
            end
         end
         bfla_pkg::CMD_TOP_GROW: begin
            if (full) begin
               r.status = bfla_pkg::STAT_REGIONS_MEET;
            end else if (free_empty) begin
               r.status = bfla_pkg::STAT_LIST_EMPTY;
            end else begin
               take_block(BLK_W'(top_blocks));
               top_blocks++;
            end
         end
         bfla_pkg::CMD_TOP_SHRINK: begin
            if (top_blocks == 0) begin
               r.status = bfla_pkg::STAT_REGION_EMPTY;
            end else begin
               top_blocks--;
               put_block(BLK_W'(top_blocks));
            end
         end
         bfla_pkg::CMD_BOT_GROW: begin
            if (full) begin
               r.status = bfla_pkg::STAT_REGIONS_MEET;
            end else if (free_empty) begin
               r.status = bfla_pkg::STAT_LIST_EMPTY;
            end else begin
               take_block(BLK_W'(NUM_BLOCKS - 1 - bot_blocks));
               bot_blocks++;
            end
         end
         bfla_pkg::CMD_BOT_SHRINK: begin
            if (bot_blocks == 0) begin
               r.status = bfla_pkg::STAT_REGION_EMPTY;
            end else begin
               bot_blocks--;
               put_block(BLK_W'(NUM_BLOCKS - 1 - bot_blocks));
            end
         end
         default: begin
         end
      endcase
      r.top_bytes    = BYTES_W'(region_bytes(top_blocks));
      r.bottom_bytes = BYTES_W'(region_bytes(bot_blocks));
      return r;
   endfunction

   function automatic bit is_held(int blk);
      foreach (held_blocks[k]) begin
         if (held_blocks[k] == blk) begin
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   task automatic report_mismatch(string what, int got_v, int want_v);
      mismatch_count++;
      $display("%0t: mismatch in %s: got %0d, expected %0d", $realtime, what, got_v,
               want_v);
   endtask

   // Offers one request and returns the result the predictor expects for it.
   task automatic issue_request(input logic [CMD_W-1:0] cmd, input logic [BLK_W-1:0] idx,
                                output alloc_result_type res);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, idx, cmd};
      do begin
         @(posedge clock);
      end while (!req_tready);
      res = predict_allocator(cmd, idx);
      pending_results.push_back(res);
   endtask

   // Holds the sender back until every expected result has come.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Walks both regions into each other, empties the list, and hits every refusal.
   task automatic test_region_limits();
      alloc_result_type res;
      issue_request(bfla_pkg::CMD_TOP_SHRINK, 4'd0, res);
      issue_request(bfla_pkg::CMD_BOT_SHRINK, 4'd0, res);
      issue_request(CMD_SPARE_6, 4'hA, res);
      issue_request(CMD_SPARE_7, 4'hF, res);
      repeat (8) issue_request(bfla_pkg::CMD_TOP_GROW, 4'd0, res);
      // The bottom region takes the remaining blocks, the head block last, emptying the list.
      repeat (8) issue_request(bfla_pkg::CMD_BOT_GROW, 4'd5, res);
      issue_request(bfla_pkg::CMD_TOP_GROW, 4'd0, res);
      issue_request(bfla_pkg::CMD_ALLOC, 4'd0, res);
      issue_request(bfla_pkg::CMD_TOP_SHRINK, 4'd0, res);
      issue_request(bfla_pkg::CMD_BOT_GROW, 4'd0, res);
      issue_request(bfla_pkg::CMD_BOT_GROW, 4'd0, res);
      issue_request(bfla_pkg::CMD_BOT_SHRINK, 4'd0, res);
      issue_request(bfla_pkg::CMD_ALLOC, 4'd0, res);
      issue_request(bfla_pkg::CMD_TOP_GROW, 4'd0, res);
      issue_request(bfla_pkg::CMD_FREE, res.given_block, res);
      issue_request(bfla_pkg::CMD_FREE, 4'd7, res);
      drain_results();
   endtask

   // Mostly well-formed traffic: frees return blocks that were handed out, and a region
   // only grows over a block that is not in use. A few requests are arbitrary.
   task automatic test_random_traffic(int n_items);
      alloc_result_type res;
      int               pick;
      int               slot;
      bit               meet;
      for (int k = 0; k < n_items; k++) begin
         pick = $urandom_range(99);
         meet = (top_blocks + bot_blocks) >= NUM_BLOCKS;
         if (pick < 4) begin
            issue_request(CMD_W'($urandom_range(7)), BLK_W'($urandom_range(15)), res);
         end else if (pick < 32 || (pick < 58 && held_blocks.size() == 0)) begin
            issue_request(bfla_pkg::CMD_ALLOC, BLK_W'($urandom_range(15)), res);
            if (res.status == bfla_pkg::STAT_OK) begin
               held_blocks.push_back(res.given_block);
            end
         end else if (pick < 58) begin
            slot = $urandom_range(held_blocks.size() - 1);
            issue_request(bfla_pkg::CMD_FREE, BLK_W'(held_blocks[slot]), res);
            held_blocks.delete(slot);
         end else if (pick < 79) begin
            if (pick < 70 && (meet || !is_held(top_blocks))) begin
               issue_request(bfla_pkg::CMD_TOP_GROW, BLK_W'($urandom_range(15)), res);
            end else begin
               issue_request(bfla_pkg::CMD_TOP_SHRINK, BLK_W'($urandom_range(15)), res);
            end
         end else begin
            if (pick < 91 && (meet || !is_held(NUM_BLOCKS - 1 - bot_blocks))) begin
               issue_request(bfla_pkg::CMD_BOT_GROW, BLK_W'($urandom_range(15)), res);
            end else begin
               issue_request(bfla_pkg::CMD_BOT_SHRINK, BLK_W'($urandom_range(15)), res);
            end
         end
      end
      drain_results();
   endtask

   // The receiver holds off for a long stretch while the sender keeps offering requests.
   task automatic test_result_backpressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_req = 300;
      test_random_traffic(24);
   endtask

   // Receiver: random stalls, long hold-offs, and the check of each result.
   always @(posedge clock) begin : rsp_side
      static int        hold_left = 0;
      alloc_result_type got;
      alloc_result_type want;
      if (hold_left == 0 && hold_req != 0) begin
         hold_left = hold_req;
         hold_req  = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = alloc_result_type'(rsp_tdata);
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result", int'(rsp_tdata), 0);
         end else begin
            want = pending_results.pop_front();
            if (got.given_block !== want.given_block) begin
               report_mismatch("given_block", got.given_block, want.given_block);
            end
            if (got.status !== want.status) begin
               report_mismatch("status", got.status, want.status);
            end
            if (got.top_bytes !== want.top_bytes) begin
               report_mismatch("top_bytes", got.top_bytes, want.top_bytes);
            end
            if (got.bottom_bytes !== want.bottom_bytes) begin
               report_mismatch("bottom_bytes", got.bottom_bytes, want.bottom_bytes);
            end
         end
      end
   end

   // Ends the run when neither side has moved a request for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("** block_free_list_allocator: FAILED **");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int half;
      int tail;
      // The reset ring visits h, h+1, h-1, h+2, h-2, ... down to block 0, then back to h.
      half = NUM_BLOCKS / 2;
      tail = half;
      for (int k = 1; k <= half; k++) begin
         if (half + k < NUM_BLOCKS) begin
            succ_link[tail]     = BLK_W'(half + k);
            pred_link[half + k] = BLK_W'(tail);
            tail = half + k;
         end
         succ_link[tail]     = BLK_W'(half - k);
         pred_link[half - k] = BLK_W'(tail);
         tail = half - k;
      end
      succ_link[tail] = BLK_W'(half);
      pred_link[half] = BLK_W'(tail);
      free_head  = BLK_W'(half);
      free_empty = 1'b0;
      top_blocks = 0;
      bot_blocks = 0;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_region_limits();
      test_result_backpressure();
      send_idle_pct = 36;
      recv_idle_pct = 60;
      test_random_traffic(420);
      send_idle_pct = 60;
      recv_idle_pct = 36;
      test_random_traffic(420);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_traffic(410);

      if (mismatch_count == 0) begin
         $display("** block_free_list_allocator: PASSED **");
      end else begin
         $display("** block_free_list_allocator: FAILED **");
      end
      $finish;
   end

endmodule

FILE: sim.f
hw/rtl/bfla_pkg.sv
hw/rtl/bfla_links.sv
hw/rtl/bfla_seq.sv
hw/rtl/block_free_list_allocator.sv
tb/tb_block_free_list_allocator.sv
